// ----- hdl/rdq_pkg.sv -----
package rdq_pkg;

    localparam int DEPTH  = 16;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int WORD_W = 32;

    typedef enum logic [2:0] {
        CMD_PUSH_BACK  = 3'd0,
        CMD_PUSH_FRONT = 3'd1,
        CMD_POP_BACK   = 3'd2,
        CMD_POP_FRONT  = 3'd3,
        CMD_REVERSE    = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2
    } status_t;

    // what every cell does on the next edge
    typedef enum logic [1:0] {
        OP_HOLD       = 2'd0,
        OP_SHIFT_UP   = 2'd1,
        OP_SHIFT_DOWN = 2'd2,
        OP_WRITE_AT   = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t                   op;
        logic [CNT_W-1:0]           count;
        logic signed [WORD_W-1:0]   word;
    } cell_ctl_t;

    localparam logic signed [WORD_W-1:0] EMPTY_WORD = '1;

endpackage

// ----- hdl/rdq_cmd_if.sv -----
interface rdq_cmd_if;
    logic                                valid;
    logic                                ready;
    logic [2:0]                          cmd;
    logic signed [rdq_pkg::WORD_W-1:0]   value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);
endinterface

// ----- hdl/rdq_res_if.sv -----
interface rdq_res_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          status;
    logic signed [rdq_pkg::WORD_W-1:0]   front_value;
    logic signed [rdq_pkg::WORD_W-1:0]   back_value;
    logic [rdq_pkg::CNT_W-1:0]           occupancy;

    modport source (output valid, output status, output front_value, output back_value,
                    output occupancy, input ready);
    modport sink   (input valid, input status, input front_value, input back_value,
                    input occupancy, output ready);
endinterface

// ----- hdl/rdq_cell.sv -----
module rdq_cell (
    input  logic                                clk,
    input  rdq_pkg::cell_ctl_t                  ctl,
    input  logic [rdq_pkg::IDX_W-1:0]           idx,
    input  logic signed [rdq_pkg::WORD_W-1:0]   lower_data,
    input  logic signed [rdq_pkg::WORD_W-1:0]   upper_data,
    output logic signed [rdq_pkg::WORD_W-1:0]   data,
    output logic                                is_last
);

    logic signed [rdq_pkg::WORD_W-1:0] data_reg;
    logic signed [rdq_pkg::WORD_W-1:0] data_next;
    logic [rdq_pkg::CNT_W-1:0]         pos;

    assign pos = rdq_pkg::CNT_W'(idx);

    always_comb
    begin
        data_next = data_reg;
        unique case (ctl.op)
            rdq_pkg::OP_HOLD:       data_next = data_reg;
            rdq_pkg::OP_SHIFT_UP:   data_next = lower_data;
            rdq_pkg::OP_SHIFT_DOWN: data_next = upper_data;
            rdq_pkg::OP_WRITE_AT:
            begin
                if (pos == ctl.count)
                    data_next = ctl.word;
            end
            default:                data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data    = data_reg;
    assign is_last = (ctl.count == pos + rdq_pkg::CNT_W'(1));

endmodule

// ----- hdl/reversible_double_ended_queue.sv -----
// Bounded double-ended queue of signed 32-bit words with an O(1) reverse command.
// Words sit in a row of DEPTH cells, physical first entry in cell 0; a push or pop
// at the physical front shifts the whole row by one cell, one at the back writes
// or drops at the cell that the count points to. Reversal only flips a flag that
// swaps the logical ends. The cells update on the transfer edge, and the result
// (front/back words read from the updated row) is registered once the output
// register is free or being read. A new command is taken while the previous
// result still waits in the output register; a second one waits until that
// result is transferred. Pop on empty and push on full change nothing and
// report status 1 and 2; unused command codes change nothing.
module reversible_double_ended_queue (
    input  logic        clk,
    input  logic        rst_n,
    rdq_cmd_if.sink     req,
    rdq_res_if.source   rsp
);

    localparam logic [rdq_pkg::CNT_W-1:0] FULL_COUNT = rdq_pkg::CNT_W'(rdq_pkg::DEPTH);

    logic                                not_empty;
    logic [rdq_pkg::CNT_W-1:0]           cnt_reg;
    logic [rdq_pkg::CNT_W-1:0]           cnt_next;
    logic                                rev_reg;
    logic                                rev_next;
    logic                                pend_reg;
    rdq_pkg::status_t                    stat_reg;
    rdq_pkg::status_t                    stat_next;
    logic                                out_valid_reg;
    rdq_pkg::status_t                    out_status_reg;
    logic signed [rdq_pkg::WORD_W-1:0]   out_front_reg;
    logic signed [rdq_pkg::WORD_W-1:0]   out_back_reg;
    logic [rdq_pkg::CNT_W-1:0]           out_occ_reg;

    logic                                accept;
    logic                                load;
    logic                                to_last;
    rdq_pkg::cell_op_t                   cmd_op;
    rdq_pkg::cell_ctl_t                  ctl;
    logic signed [rdq_pkg::WORD_W-1:0]   cell_data [rdq_pkg::DEPTH];
    logic                                cell_last [rdq_pkg::DEPTH];
    logic signed [rdq_pkg::WORD_W-1:0]   first_word;
    logic signed [rdq_pkg::WORD_W-1:0]   last_word;
    logic signed [rdq_pkg::WORD_W-1:0]   front_word;
    logic signed [rdq_pkg::WORD_W-1:0]   back_word;

    assign not_empty = (cnt_reg != '0);
    assign req.ready = !pend_reg;
    assign accept    = req.valid && req.ready;
    assign load      = pend_reg && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        cmd_op    = rdq_pkg::OP_HOLD;
        cnt_next  = cnt_reg;
        rev_next  = rev_reg;
        stat_next = rdq_pkg::ST_DONE;
        to_last   = 1'b0;
        unique case (req.cmd)
            rdq_pkg::CMD_PUSH_BACK, rdq_pkg::CMD_PUSH_FRONT:
            begin
                if (cnt_reg == FULL_COUNT)
                    stat_next = rdq_pkg::ST_OVER;
                else
                begin
                    to_last  = (req.cmd == rdq_pkg::CMD_PUSH_BACK) != rev_reg;
                    cmd_op   = to_last ? rdq_pkg::OP_WRITE_AT : rdq_pkg::OP_SHIFT_UP;
                    cnt_next = cnt_reg + rdq_pkg::CNT_W'(1);
                end
            end
            rdq_pkg::CMD_POP_BACK, rdq_pkg::CMD_POP_FRONT:
            begin
                if (!not_empty)
                    stat_next = rdq_pkg::ST_UNDER;
                else
                begin
                    to_last  = (req.cmd == rdq_pkg::CMD_POP_BACK) != rev_reg;
                    // dropping the last word only needs the count to shrink
                    cmd_op   = to_last ? rdq_pkg::OP_HOLD : rdq_pkg::OP_SHIFT_DOWN;
                    cnt_next = cnt_reg - rdq_pkg::CNT_W'(1);
                end
            end
            rdq_pkg::CMD_REVERSE:
                rev_next = !rev_reg;
            default:
                stat_next = rdq_pkg::ST_DONE;
        endcase
    end

    always_comb
    begin
        ctl.op    = accept ? cmd_op : rdq_pkg::OP_HOLD;
        ctl.count = cnt_reg;
        ctl.word  = req.value;
    end

    for (genvar g = 0; g < rdq_pkg::DEPTH; g++)
    begin : g_cell
        logic signed [rdq_pkg::WORD_W-1:0] lower;
        logic signed [rdq_pkg::WORD_W-1:0] upper;

        if (g == 0)
        begin : g_bottom
            assign lower = req.value;
        end
        else
        begin : g_lower
            assign lower = cell_data[g-1];
        end

        if (g == rdq_pkg::DEPTH - 1)
        begin : g_top
            assign upper = '0;
        end
        else
        begin : g_upper
            assign upper = cell_data[g+1];
        end

        rdq_cell u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .idx        (rdq_pkg::IDX_W'(g)),
            .lower_data (lower),
            .upper_data (upper),
            .data       (cell_data[g]),
            .is_last    (cell_last[g])
        );
    end

    // exactly one cell flags itself as last when the row is not empty
    always_comb
    begin
        last_word = '0;
        for (int i = 0; i < rdq_pkg::DEPTH; i++)
            last_word = last_word | (cell_last[i] ? cell_data[i] : '0);
    end

    assign first_word = cell_data[0];

    always_comb
    begin
        if (!not_empty)
        begin
            front_word = rdq_pkg::EMPTY_WORD;
            back_word  = rdq_pkg::EMPTY_WORD;
        end
        else if (rev_reg)
        begin
            front_word = last_word;
            back_word  = first_word;
        end
        else
        begin
            front_word = first_word;
            back_word  = last_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            rev_reg       <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                cnt_reg <= cnt_next;
                rev_reg <= rev_next;
            end
            if (accept)
                pend_reg <= 1'b1;
            else if (load)
                pend_reg <= 1'b0;
            if (load)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            stat_reg <= stat_next;
        if (load)
        begin
            out_status_reg <= stat_reg;
            out_front_reg  <= front_word;
            out_back_reg   <= back_word;
            out_occ_reg    <= cnt_reg;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.front_value = out_front_reg;
    assign rsp.back_value  = out_back_reg;
    assign rsp.occupancy   = out_occ_reg;

    a_accept_pends: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> pend_reg)
        else $error("transfer did not leave a result pending");

    a_pend_waits_on_full_output: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg && !load) |=> (pend_reg && rsp.valid))
        else $error("pending result lost while output register was full");

    a_full_push_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && stat_next == rdq_pkg::ST_OVER) |=> $stable(cnt_reg))
        else $error("ignored push changed the count");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= FULL_COUNT)
        else $error("count exceeds depth");

    a_empty_reports_minus_one: assert property (@(posedge clk) disable iff (!rst_n)
        (load && !not_empty) |=> (rsp.front_value == rdq_pkg::EMPTY_WORD
                                  && rsp.back_value == rdq_pkg::EMPTY_WORD))
        else $error("empty queue result not reported as minus one");

endmodule

// ----- bench/reversible_double_ended_queue_tb.sv -----
module reversible_double_ended_queue_tb;

    localparam logic [2:0] CMD_SPARE_LO = 3'd5;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;
    localparam logic signed [rdq_pkg::WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
    localparam logic signed [rdq_pkg::WORD_W-1:0] WORD_MAX = 32'sh7fff_ffff;
    localparam int SETTLE_CYCLES = 10;

    typedef enum int {
        IDLE_NONE,
        IDLE_LIGHT,
        IDLE_HEAVY
    } idle_mode_t;

    typedef struct {
        rdq_pkg::status_t                  status;
        logic signed [rdq_pkg::WORD_W-1:0] front;
        logic signed [rdq_pkg::WORD_W-1:0] back;
        logic [rdq_pkg::CNT_W-1:0]         occupancy;
    } deque_view_t;

    logic clk;
    logic rst_n;

    rdq_cmd_if cmd_ch ();
    rdq_res_if res_ch ();

    reversible_double_ended_queue dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (cmd_ch),
        .rsp   (res_ch)
    );

    // shadow deque
    logic signed [rdq_pkg::WORD_W-1:0] shadow_ring [rdq_pkg::DEPTH];
    int                                shadow_head;
    int                                shadow_count;
    bit                                shadow_rev;

    deque_view_t expected_views [$];
    deque_view_t want;
    int          mismatches;
    idle_mode_t  src_idle;
    idle_mode_t  snk_idle;
    int          snk_stall;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic int pick_gap(idle_mode_t mode);
        int r;
        r = $urandom_range(99);
        if (mode == IDLE_NONE)
            return 0;
        if (mode == IDLE_LIGHT)
        begin
            if (r < 70)
                return 0;
            if (r < 95)
                return $urandom_range(1, 3);
            return $urandom_range(8, 25);
        end
        if (r < 30)
            return 0;
        if (r < 85)
            return $urandom_range(1, 4);
        return $urandom_range(8, 25);
    endfunction

    function automatic logic signed [rdq_pkg::WORD_W-1:0] pick_word();
        case ($urandom_range(19))
            0: return WORD_MIN;
            1: return WORD_MAX;
            2: return '0;
            3: return rdq_pkg::EMPTY_WORD;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [2:0] pick_cmd(int push_pct);
        int r;
        r = $urandom_range(99);
        if (r < 4)
            return 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
        if (r < 14)
            return rdq_pkg::CMD_REVERSE;
        if ($urandom_range(99) < push_pct)
            return $urandom_range(1) ? rdq_pkg::CMD_PUSH_FRONT : rdq_pkg::CMD_PUSH_BACK;
        return $urandom_range(1) ? rdq_pkg::CMD_POP_FRONT : rdq_pkg::CMD_POP_BACK;
    endfunction

    function automatic void shadow_reset();
        shadow_head  = 0;
        shadow_count = 0;
        shadow_rev   = 1'b0;
    endfunction

    // apply one command to the shadow deque and queue up the view it should report
    function automatic void shadow_apply(logic [2:0] c, logic signed [rdq_pkg::WORD_W-1:0] v);
        deque_view_t view;
        bit          at_last;
        int          last_idx;
        view.status = rdq_pkg::ST_DONE;
        view.front  = rdq_pkg::EMPTY_WORD;
        view.back   = rdq_pkg::EMPTY_WORD;
        case (c)
            rdq_pkg::CMD_PUSH_BACK, rdq_pkg::CMD_PUSH_FRONT:
            begin
                if (shadow_count >= rdq_pkg::DEPTH)
                    view.status = rdq_pkg::ST_OVER;
                else
                begin
                    at_last = (c == rdq_pkg::CMD_PUSH_BACK) != shadow_rev;
                    if (at_last)
                        shadow_ring[(shadow_head + shadow_count) % rdq_pkg::DEPTH] = v;
                    else
                    begin
                        shadow_head = (shadow_head + rdq_pkg::DEPTH - 1) % rdq_pkg::DEPTH;
                        shadow_ring[shadow_head] = v;
                    end
                    shadow_count++;
                end
            end
            rdq_pkg::CMD_POP_BACK, rdq_pkg::CMD_POP_FRONT:
            begin
                if (shadow_count == 0)
                    view.status = rdq_pkg::ST_UNDER;
                else
                begin
                    at_last = (c == rdq_pkg::CMD_POP_BACK) != shadow_rev;
                    if (!at_last)
                        shadow_head = (shadow_head + 1) % rdq_pkg::DEPTH;
                    shadow_count--;
                end
            end
            rdq_pkg::CMD_REVERSE:
                shadow_rev = !shadow_rev;
            default:
                ;
        endcase
        if (shadow_count != 0)
        begin
            last_idx   = (shadow_head + shadow_count - 1) % rdq_pkg::DEPTH;
            view.front = shadow_rev ? shadow_ring[last_idx] : shadow_ring[shadow_head];
            view.back  = shadow_rev ? shadow_ring[shadow_head] : shadow_ring[last_idx];
        end
        view.occupancy = rdq_pkg::CNT_W'(shadow_count);
        expected_views = {expected_views, view};
    endfunction

    // valid is left high after the transfer so a back-to-back command keeps it up
    task automatic send_cmd(logic [2:0] c, logic signed [rdq_pkg::WORD_W-1:0] v);
        int gap;
        gap = pick_gap(src_idle);
        repeat (gap)
        begin
            cmd_ch.valid <= 1'b0;
            cmd_ch.cmd   <= 3'($urandom);
            cmd_ch.value <= $urandom;
            @(posedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.cmd   <= c;
        cmd_ch.value <= v;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        shadow_apply(c, v);
    endtask

    task automatic test_empty_queue();
        src_idle = IDLE_LIGHT;
        snk_idle = IDLE_LIGHT;
        send_cmd(rdq_pkg::CMD_POP_BACK, pick_word());
        send_cmd(rdq_pkg::CMD_POP_FRONT, pick_word());
        send_cmd(CMD_SPARE_LO, WORD_MAX);
        send_cmd(rdq_pkg::CMD_REVERSE, WORD_MIN);
        send_cmd(rdq_pkg::CMD_POP_FRONT, pick_word());
    endtask

    // fill from both ends, hit both overflow kinds, reverse, try a spare code, then peel a word off each end
    task automatic test_full_queue();
        logic signed [rdq_pkg::WORD_W-1:0] specials [4];
        specials = '{WORD_MIN, WORD_MAX, '0, rdq_pkg::EMPTY_WORD};
        src_idle = IDLE_NONE;
        snk_idle = IDLE_NONE;
        for (int i = 0; i < rdq_pkg::DEPTH; i++)
            send_cmd(i[0] ? rdq_pkg::CMD_PUSH_FRONT : rdq_pkg::CMD_PUSH_BACK,
                     i < 4 ? specials[i] : pick_word());
        send_cmd(rdq_pkg::CMD_PUSH_BACK, pick_word());
        send_cmd(rdq_pkg::CMD_PUSH_FRONT, pick_word());
        send_cmd(rdq_pkg::CMD_REVERSE, pick_word());
        send_cmd(CMD_SPARE_HI, pick_word());
        send_cmd(rdq_pkg::CMD_POP_BACK, pick_word());
        send_cmd(rdq_pkg::CMD_POP_FRONT, pick_word());
    endtask

    // blocks alternate between filling, draining and balanced traffic
    task automatic test_random_traffic(int blocks, int per_block);
        int push_bias [6];
        push_bias = '{75, 20, 50, 90, 10, 55};
        for (int b = 0; b < blocks; b++)
        begin
            src_idle = idle_mode_t'(b % 3);
            snk_idle = idle_mode_t'((b / 3 + b) % 3);
            for (int i = 0; i < per_block; i++)
                send_cmd(pick_cmd(push_bias[b % 6]), pick_word());
        end
    endtask

    task automatic note_mismatch(string field, logic [rdq_pkg::WORD_W-1:0] exp_v,
                                 logic [rdq_pkg::WORD_W-1:0] got_v);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s mismatch: expected %0d, got %0d",
                     $time, field, $signed(exp_v), $signed(got_v));
    endtask

    initial
    begin
        res_ch.ready = 1'b0;
        snk_stall = 0;
        forever
        begin
            @(posedge clk);
            if (snk_stall > 0)
            begin
                res_ch.ready <= 1'b0;
                snk_stall--;
            end
            else
            begin
                res_ch.ready <= 1'b1;
                snk_stall = pick_gap(snk_idle);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (expected_views.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result transfer with nothing outstanding", $time);
            end
            else
            begin
                want = expected_views[0];
                expected_views.delete(0);
                if (res_ch.status !== want.status)
                    note_mismatch("status", 32'(want.status), 32'(res_ch.status));
                if (res_ch.front_value !== want.front)
                    note_mismatch("front_value", want.front, res_ch.front_value);
                if (res_ch.back_value !== want.back)
                    note_mismatch("back_value", want.back, res_ch.back_value);
                if (res_ch.occupancy !== want.occupancy)
                    note_mismatch("occupancy", 32'(want.occupancy), 32'(res_ch.occupancy));
            end
        end
    end

    initial
    begin
        int settle_wait;
        rst_n        = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.cmd   = rdq_pkg::CMD_PUSH_BACK;
        cmd_ch.value = '0;
        mismatches   = 0;
        src_idle     = IDLE_NONE;
        snk_idle     = IDLE_NONE;
        shadow_reset();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_queue();
        test_full_queue();
        test_random_traffic(8, 100);

        cmd_ch.valid <= 1'b0;
        while (expected_views.size() != 0)
            @(posedge clk);
        settle_wait = SETTLE_CYCLES;
        repeat (settle_wait) @(posedge clk);

        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/rdq_pkg.sv
hdl/rdq_cmd_if.sv
hdl/rdq_res_if.sv
hdl/rdq_cell.sv
hdl/reversible_double_ended_queue.sv
bench/reversible_double_ended_queue_tb.sv
